[sv/hsb_pkg.sv]
// hsb_pkg: shared word types and constants for the batch heap sorter.
// No dependencies; imported by the top level, the sift engine and the checker.
`default_nettype none

package hsb_pkg;

  localparam int unsigned DATA_W = 32;

  // Input word: one element of a batch.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last_item;
  } hsb_in_t;

  // Output word: one element of the sorted batch.
  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     forced_end;
  } hsb_out_t;

endpackage

`default_nettype wire

[sv/hsb_ram.sv]
// hsb_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`default_nettype none

module hsb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              we_i,
  input  wire logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  wire logic [WIDTH-1:0]                  wdata_i,
  input  wire logic                              re_i,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr_i,
  output logic      [WIDTH-1:0]                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/hsb_sift.sv]
// hsb_sift: sift-down engine; walks one hole from a root toward the leaves.
// Depends on hsb_pkg; drives the element RAM port while it runs.
`default_nettype none

module hsb_sift
  import hsb_pkg::*;
#(
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [AW-1:0]            root_i,
  input  wire logic [CW-1:0]            len_i,
  input  wire logic signed [DATA_W-1:0] val_i,
  input  wire logic [DATA_W-1:0]        rdata_i,
  output logic                          re_o,
  output logic [AW-1:0]                 raddr_o,
  output logic                          we_o,
  output logic [AW-1:0]                 waddr_o,
  output logic [DATA_W-1:0]             wdata_o,
  output logic                          done_o
);

  localparam int unsigned CHW = AW + 2;  // child index width, holds 2h+2

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_L,
    S_RD_R,
    S_DEC
  } sift_state_e;

  sift_state_e state_q;

  logic [AW-1:0]            h_q;
  logic [CW-1:0]            len_q;
  logic signed [DATA_W-1:0] val_q;
  logic signed [DATA_W-1:0] lv_q;
  logic                     has_r_q;

  logic [CHW-1:0]           left_w;
  logic [CHW-1:0]           right_w;
  logic                     left_ok;
  logic                     right_ok;
  logic signed [DATA_W-1:0] rv;
  logic signed [DATA_W-1:0] big;
  logic                     gt_l;
  logic                     gt_r;

  assign left_w   = {1'b0, h_q, 1'b1};
  assign right_w  = left_w + CHW'(1);
  assign left_ok  = left_w < CHW'(len_q);
  assign right_ok = right_w < CHW'(len_q);

  // Ties keep the parent and favor the left child.
  assign rv   = $signed(rdata_i);
  assign gt_l = lv_q > val_q;
  assign big  = gt_l ? lv_q : val_q;
  assign gt_r = has_r_q && (rv > big);

  always_comb begin
    re_o    = 1'b0;
    raddr_o = '0;
    we_o    = 1'b0;
    waddr_o = h_q;
    wdata_o = val_q;
    done_o  = 1'b0;
    case (state_q)
      S_RD_L: begin
        if (left_ok) begin
          re_o    = 1'b1;
          raddr_o = left_w[AW-1:0];
        end else begin
          we_o   = 1'b1;
          done_o = 1'b1;
        end
      end
      S_RD_R: begin
        if (right_ok) begin
          re_o    = 1'b1;
          raddr_o = right_w[AW-1:0];
        end
      end
      S_DEC: begin
        we_o = 1'b1;
        if (gt_r) begin
          wdata_o = rv;
        end else if (gt_l) begin
          wdata_o = lv_q;
        end else begin
          done_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (start_i) state_q <= S_RD_L;
        S_RD_L: state_q <= left_ok ? S_RD_R : S_IDLE;
        S_RD_R: state_q <= S_DEC;
        S_DEC:  state_q <= (gt_r || gt_l) ? S_RD_L : S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          h_q   <= root_i;
          len_q <= len_i;
          val_q <= val_i;
        end
      end
      S_RD_R: begin
        lv_q    <= $signed(rdata_i);
        has_r_q <= right_ok;
      end
      S_DEC: begin
        if (gt_r) begin
          h_q <= right_w[AW-1:0];
        end else if (gt_l) begin
          h_q <= left_w[AW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[sv/heap_sort_batch.sv]
// heap_sort_batch: loads a batch of signed words, heap-sorts it in RAM, streams it out.
// Loading takes one word per cycle; sorting is bounded by the single RAM read port
//   (three accesses per sift level), then each output word is read and registered.
// Throughput: one batch at a time; no input is taken from close of a batch until its
//   last word sits in the output register.
// Reset: rst_ni async active low clears the count and control; RAM contents are not cleared.
`default_nettype none

module heap_sort_batch
  import hsb_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire hsb_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output hsb_out_t      out_data_o
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [3:0] {
    T_LOAD,     // taking words into RAM
    T_BLD_CHK,  // heap build: next root or move on
    T_BLD_GO,   // root word arrives, start sift
    T_SIFT,     // sift engine owns the RAM port
    T_EXT_CHK,  // extraction: next tail or move on
    T_EXT_RDK,  // root arrives, fetch tail
    T_EXT_GO,   // tail arrives; old root to tail, sift tail from root
    T_EMIT_RD,  // fetch next sorted word
    T_EMIT_CAP  // load it into the output register
  } top_state_e;

  top_state_e state_q;

  logic [CW-1:0]     cnt_q;     // words loaded into the open batch
  logic [CW-1:0]     n_q;       // size of the closed batch
  logic [CW-1:0]     k_q;       // build root+1 / extraction heap length
  logic [CW-1:0]     e_q;       // emit index
  logic              forced_q;  // batch closed by a full store
  logic              ret_bld_q; // sift belongs to the build phase
  logic [DATA_W-1:0] tmp_q;     // old root during a swap
  logic              out_valid_q;
  hsb_out_t          out_q;

  logic              in_fire;
  logic              closes;
  logic              out_free;
  logic [CW-1:0]     n_new;
  logic [CW-1:0]     km1;
  logic [CW-1:0]     nm1;

  // RAM port, top side and sift side
  logic              top_re, top_we;
  logic [AW-1:0]     top_raddr, top_waddr;
  logic [DATA_W-1:0] top_wdata;
  logic              sft_re, sft_we;
  logic [AW-1:0]     sft_raddr, sft_waddr;
  logic [DATA_W-1:0] sft_wdata;
  logic              ram_re, ram_we;
  logic [AW-1:0]     ram_raddr, ram_waddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              sift_start;
  logic [AW-1:0]     sift_root;
  logic [CW-1:0]     sift_len;
  logic              sift_done;

  assign in_ready_o  = (state_q == T_LOAD);
  assign in_fire     = in_valid_i && in_ready_o;
  assign closes      = in_data_i.last_item || (cnt_q == CW'(MAX_ITEMS - 1));
  assign n_new       = cnt_q + CW'(1);
  assign km1         = k_q - CW'(1);
  assign nm1         = n_q - CW'(1);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Top-side RAM requests and sift launch
  always_comb begin
    top_re     = 1'b0;
    top_raddr  = '0;
    top_we     = 1'b0;
    top_waddr  = '0;
    top_wdata  = in_data_i.value;
    sift_start = 1'b0;
    sift_root  = '0;
    sift_len   = n_q;
    case (state_q)
      T_LOAD: begin
        top_we    = in_fire;
        top_waddr = cnt_q[AW-1:0];
      end
      T_BLD_CHK: begin
        if (k_q != '0) begin
          top_re    = 1'b1;
          top_raddr = km1[AW-1:0];
        end
      end
      T_BLD_GO: begin
        sift_start = 1'b1;
        sift_root  = km1[AW-1:0];
      end
      T_EXT_CHK: begin
        top_re = (k_q > CW'(1));
      end
      T_EXT_RDK: begin
        top_re    = 1'b1;
        top_raddr = km1[AW-1:0];
      end
      T_EXT_GO: begin
        top_we     = 1'b1;
        top_waddr  = km1[AW-1:0];
        top_wdata  = tmp_q;
        sift_start = 1'b1;
        sift_len   = km1;
      end
      T_EMIT_RD: begin
        top_re    = out_free;
        top_raddr = e_q[AW-1:0];
      end
      default: ;
    endcase
  end

  // The sift engine has the port only while the top waits on it.
  always_comb begin
    if (state_q == T_SIFT) begin
      ram_re    = sft_re;
      ram_raddr = sft_raddr;
      ram_we    = sft_we;
      ram_waddr = sft_waddr;
      ram_wdata = sft_wdata;
    end else begin
      ram_re    = top_re;
      ram_raddr = top_raddr;
      ram_we    = top_we;
      ram_waddr = top_waddr;
      ram_wdata = top_wdata;
    end
  end

  hsb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hsb_sift #(
    .AW (AW),
    .CW (CW)
  ) u_sift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sift_start),
    .root_i  (sift_root),
    .len_i   (sift_len),
    .val_i   ($signed(ram_rdata)),
    .rdata_i (ram_rdata),
    .re_o    (sft_re),
    .raddr_o (sft_raddr),
    .we_o    (sft_we),
    .waddr_o (sft_waddr),
    .wdata_o (sft_wdata),
    .done_o  (sift_done)
  );

  // Sequencer: state, counters and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      e_q         <= '0;
      forced_q    <= 1'b0;
      ret_bld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == T_EMIT_CAP) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        T_LOAD: begin
          if (in_fire) begin
            if (closes) begin
              cnt_q    <= '0;
              n_q      <= n_new;
              k_q      <= n_new >> 1;
              forced_q <= !in_data_i.last_item;
              state_q  <= T_BLD_CHK;
            end else begin
              cnt_q <= n_new;
            end
          end
        end
        T_BLD_CHK: begin
          if (k_q == '0) begin
            k_q     <= n_q;
            state_q <= T_EXT_CHK;
          end else begin
            state_q <= T_BLD_GO;
          end
        end
        T_BLD_GO: begin
          ret_bld_q <= 1'b1;
          state_q   <= T_SIFT;
        end
        T_SIFT: begin
          if (sift_done) begin
            k_q     <= km1;
            state_q <= ret_bld_q ? T_BLD_CHK : T_EXT_CHK;
          end
        end
        T_EXT_CHK: begin
          if (k_q > CW'(1)) begin
            state_q <= T_EXT_RDK;
          end else begin
            e_q     <= '0;
            state_q <= T_EMIT_RD;
          end
        end
        T_EXT_RDK: state_q <= T_EXT_GO;
        T_EXT_GO: begin
          ret_bld_q <= 1'b0;
          state_q   <= T_SIFT;
        end
        T_EMIT_RD: begin
          if (out_free) state_q <= T_EMIT_CAP;
        end
        T_EMIT_CAP: begin
          if (e_q == nm1) begin
            state_q <= T_LOAD;
          end else begin
            e_q     <= e_q + CW'(1);
            state_q <= T_EMIT_RD;
          end
        end
        default: state_q <= T_LOAD;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == T_EXT_RDK) begin
      tmp_q <= ram_rdata;
    end
    if (state_q == T_EMIT_CAP) begin
      out_q.sorted_value <= $signed(ram_rdata);
      out_q.last_out     <= (e_q == nm1);
      out_q.forced_end   <= forced_q;
    end
  end

endmodule

`default_nettype wire

[sv/hsb_checker.sv]
// hsb_checker: port-level assertions for heap_sort_batch, bound to the top level.
// Depends on hsb_pkg for the word types.
`default_nettype none

module hsb_checker
  import hsb_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire hsb_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire hsb_out_t out_data_o
);

  // A stalled output word stays up.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A stalled output word keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // A word flagged last closes the batch; loading stops.
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.last_item |=> !in_ready_o)
    else $error("input still open after last word");

  // Results only appear while the sorter is off the input side.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result emitted while loading");

endmodule

bind heap_sort_batch hsb_checker u_hsb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
